// ===== rtl/mabl_pkg.sv =====
// Package for the masked address blocklist: table size, derived widths,
// action codes and the command and result word types. No dependencies.
package mabl_pkg;

    localparam int MAX_RULES = 256;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);
    localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int OUT_CNT_W = 9;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_CHECK = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] address;
        logic [31:0] mask;
    } cmd_word_t;

    typedef struct packed {
        logic                 matched;
        logic                 table_full;
        logic [OUT_CNT_W-1:0] rule_count;
    } result_word_t;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] netmask;
    } rule_t;

endpackage

// ===== rtl/masked_address_blocklist.sv =====
// Top level of the masked address blocklist: rule memory, count and search sequencer.
// Depends on mabl_pkg.
//
//  Channel   Signals                 Direction  Handshake
//  command   start, cmd, busy        in         word taken when start && !busy
//  result    done, result            out        one-cycle strobe, cannot be stalled
//
// Add, clear and unused actions give their result in the cycle after the word is taken.
// A check walks the stored rules through the single read port of the rule memory, one
// rule per cycle, and ends early on a hit.
// Reset empties the table at once by zeroing the rule count; the memory is not cleared.
// busy is high while a check is walking the table; no new word is taken then.
module masked_address_blocklist (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  mabl_pkg::cmd_word_t    cmd,
    output logic                   busy,
    output logic                   done,
    output mabl_pkg::result_word_t result
);
    import mabl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    rule_t              rule_mem [MAX_RULES];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               issue_done_reg, issue_done_next;
    logic               pend_reg, pend_next;
    logic               pend_last_reg, pend_last_next;
    logic [31:0]        addr_reg, addr_next;
    logic               done_reg, done_next;
    result_word_t       result_reg, result_next;
    rule_t              rdata_reg;

    logic               wr_en;
    rule_t              wr_data;
    logic               accept;
    logic               hit;
    logic [IDX_W-1:0]   last_idx;

    assign accept   = start && (state_reg == ST_IDLE);
    assign hit      = (addr_reg & rdata_reg.netmask) == rdata_reg.base;
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign wr_data  = '{base: cmd.address & cmd.mask, netmask: cmd.mask};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rule_mem[count_reg[IDX_W-1:0]] <= wr_data;
        end
        rdata_reg <= rule_mem[rd_idx_reg];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        issue_done_next = issue_done_reg;
        pend_next       = 1'b0;
        pend_last_next  = 1'b0;
        addr_next       = addr_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        wr_en           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next.matched    = 1'b0;
                    result_next.table_full = 1'b0;
                    result_next.rule_count = OUT_CNT_W'(count_reg);
                    done_next              = 1'b1;
                    case (cmd.action)
                        ACT_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_RULES))
                            begin
                                result_next.table_full = 1'b1;
                            end
                            else
                            begin
                                wr_en                  = 1'b1;
                                count_next             = count_reg + CNT_W'(1);
                                result_next.rule_count = OUT_CNT_W'(count_next);
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next             = '0;
                            result_next.rule_count = '0;
                        end
                        ACT_CHECK:
                        begin
                            if (count_reg != '0)
                            begin
                                done_next       = 1'b0;
                                addr_next       = cmd.address;
                                rd_idx_next     = '0;
                                issue_done_next = 1'b0;
                                state_next      = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && (hit || pend_last_reg))
                begin
                    result_next.matched    = hit;
                    result_next.table_full = 1'b0;
                    result_next.rule_count = OUT_CNT_W'(count_reg);
                    done_next              = 1'b1;
                    state_next             = ST_IDLE;
                end
                else if (!issue_done_reg)
                begin
                    pend_next      = 1'b1;
                    pend_last_next = (rd_idx_reg == last_idx);
                    if (rd_idx_reg == last_idx)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            pend_last_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            pend_last_reg  <= pend_last_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/mabl_checker.sv =====
// Port-level checker for the masked address blocklist and its bind to the top level.
// Depends on mabl_pkg and masked_address_blocklist.
module mabl_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic                   done,
    input  mabl_pkg::result_word_t result
);
    import mabl_pkg::*;

    // Every taken word either answers at once or starts a table walk.
    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done || busy)
        else $error("taken word gave neither a result nor a walk");

    a_walk_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("table walk ended without a result");

    a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result shown while walking the table");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.table_full |-> result.rule_count == OUT_CNT_W'(MAX_RULES))
        else $error("table reported full with a count below the table size");

    a_hit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.matched |-> !result.table_full)
        else $error("hit and table full reported together");

endmodule

bind masked_address_blocklist mabl_checker u_mabl_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
